FILE: hw/rtl/ttsp_pkg.sv
// Shared types and constants for the transposition table store/probe unit.
package ttsp_pkg;

  typedef struct packed {
    logic        action;
    logic [63:0] key;
    logic [23:0] best_move;
    logic signed [15:0] score_in;
    logic [1:0]  bound_in;
    logic [6:0]  remaining_depth;
    logic [6:0]  ply;
  } in_req_t;

  typedef struct packed {
    logic        hit;
    logic [23:0] move_out;
    logic signed [15:0] score_out;
    logic [1:0]  bound_out;
    logic [6:0]  depth_out;
  } out_req_t;

  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;
  localparam logic ACT_STORE = 1'b1;

  localparam logic [1:0] REG_AGE   = 2'd0;
  localparam logic [1:0] REG_MATE  = 2'd1;
  localparam logic [1:0] REG_DEPTH = 2'd2;
  localparam logic [1:0] REG_OFFS  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_OUT
  } state_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic clear_en;
    logic take_req;
    logic decide;
    logic out_load;
  } ctl_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic clear_done;
  } dp_stat_t;

endpackage

FILE: hw/rtl/transposition_table_store_probe_unit.sv
// Top level of the transposition table store/probe unit.
//
// Requests come in on in_valid/in_stall/in_data; each is either a probe
// (action 0) or a store (action 1). Every request gives exactly one result
// on out_valid/out_stall/out_data; stores and probe misses return all zero.
// The result passes through the registered request, the bucket RAM read,
// the slot decision with bucket write-back and the result load.
// One request is in flight at a time and the controller returns to idle
// before the next request is accepted.
// A result waiting under out_stall does not block acceptance of the next
// request; that request holds in its last step until the result is taken.
// After reset a clearing sweep writes zero to every bucket, one bucket row
// a cycle; no request is accepted meanwhile.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) belong between
// requests, while nothing is in flight.
module transposition_table_store_probe_unit #(
  parameter int ENTRIES = 4096,
  parameter int SLOTS   = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ttsp_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ttsp_pkg::out_req_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  ttsp_pkg::ctl_cmd_t cmd;
  ttsp_pkg::dp_stat_t stat;

  ttsp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .stat(stat), .cmd(cmd)
  );

  ttsp_dp #(.ENTRIES(ENTRIES), .SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_data(out_data)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    !stat.clear_done |-> in_stall) else $error("request taken during clear");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take_req, cmd.decide, cmd.out_load, cmd.clear_en}))
    else $error("overlapping commands");
  a_out_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid) else $error("result lost");
endmodule

FILE: hw/rtl/ttsp_ram.sv
// Generic single-port-write, registered-read RAM.
module ttsp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/ttsp_ctrl.sv
// Sequencer: clearing sweep, then read / decide / output per request.
module ttsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 out_stall,
  output logic                 out_valid,
  input  ttsp_pkg::dp_stat_t   stat,
  output ttsp_pkg::ctl_cmd_t   cmd
);
  ttsp_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ttsp_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    cmd            = '0;
    in_stall       = 1'b1;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ttsp_pkg::ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_done) begin
          state_next = ttsp_pkg::ST_IDLE;
        end
      end
      ttsp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_req = 1'b1;
          state_next   = ttsp_pkg::ST_READ;
        end
      end
      ttsp_pkg::ST_READ: begin
        state_next = ttsp_pkg::ST_DECIDE;
      end
      ttsp_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ttsp_pkg::ST_OUT;
      end
      ttsp_pkg::ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ttsp_pkg::ST_IDLE;
        end
      end
      default: state_next = ttsp_pkg::ST_IDLE;
    endcase
  end
endmodule

FILE: hw/rtl/ttsp_dp.sv
// Datapath: bucket memory, slot choice, packing and result register.
module ttsp_dp #(
  parameter int ENTRIES = 4096,
  parameter int SLOTS   = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  ttsp_pkg::ctl_cmd_t  cmd,
  output ttsp_pkg::dp_stat_t  stat,
  input  ttsp_pkg::in_req_t   in_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output ttsp_pkg::out_req_t  out_data
);
  localparam int ROWS  = ENTRIES / SLOTS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SOFS  = $clog2(SLOTS);
  localparam int BW    = 128 * SLOTS;

  logic [14:0] current_age;
  logic [14:0] mate_threshold;
  logic [6:0]  max_depth;
  logic signed [15:0] score_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_age    <= '0;
      mate_threshold <= 15'd31000;
      max_depth      <= 7'd127;
      score_offset   <= -16'sd32767;
    end else if (cfg_we) begin
      case (cfg_index)
        ttsp_pkg::REG_AGE:   current_age    <= cfg_wdata[14:0];
        ttsp_pkg::REG_MATE:  mate_threshold <= cfg_wdata[14:0];
        ttsp_pkg::REG_DEPTH: max_depth      <= cfg_wdata[6:0];
        ttsp_pkg::REG_OFFS:  score_offset   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ttsp_pkg::in_req_t req;
  logic [RW:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      req <= in_data;
    end
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en && !clr_cnt[RW]) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end
  assign stat.clear_done = clr_cnt[RW];

  logic          we;
  logic [RW-1:0] waddr, req_row;
  logic [BW-1:0] wbucket, bucket;

  // row selected from key bits above the slot field
  always_comb begin
    if (ROWS > 1) begin
      req_row = req.key[SOFS +: RW];
    end else begin
      req_row = '0;
    end
  end

  // read issued from the held request, so the bucket is valid in the decide step
  ttsp_ram #(.WIDTH(BW), .DEPTH(ROWS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wbucket),
    .raddr(req_row),
    .rdata(bucket)
  );

  // store: mate adjust
  logic signed [17:0] thr, sc_adj, sc_pack;
  logic signed [17:0] ply_s;
  always_comb begin
    thr   = {3'b0, mate_threshold};
    ply_s = {11'b0, req.ply};
    sc_adj = 18'(req.score_in);
    if (sc_adj > thr && req.bound_in != ttsp_pkg::BOUND_UPPER) begin
      sc_adj = sc_adj + ply_s;
    end
    if (sc_adj < -thr && req.bound_in != ttsp_pkg::BOUND_LOWER) begin
      sc_adj = sc_adj - ply_s;
    end
    sc_pack = sc_adj - 18'(score_offset);
  end

  // slot scan
  logic [SW-1:0] pick, hit_slot;
  logic          found;
  logic [23:0]   mv;
  logic [23:0]   max_rank, low_rank, rank;
  logic          done;
  logic [63:0]   kw, dw, newdata, hitdata;

  always_comb begin
    // depth never exceeds 127, so it fits below the shifted age
    max_rank = {1'b0, current_age, 1'b0, max_depth};
    low_rank = max_rank;
    pick     = '0;
    done     = 1'b0;
    mv       = req.best_move;
    found    = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      kw = bucket[128*i +: 64];
      dw = bucket[128*i + 64 +: 64];
      rank = {1'b0, dw[14:0], 8'b0} + {17'b0, dw[23:17]};
      if (!found && (kw ^ dw) == req.key) begin
        found    = 1'b1;
        hit_slot = SW'(i);
      end
      if (!done) begin
        if (kw == 64'd0) begin
          pick = SW'(i);
          done = 1'b1;
        end else if ((kw ^ dw) == req.key) begin
          if (req.bound_in == ttsp_pkg::BOUND_UPPER &&
              dw[16:15] == ttsp_pkg::BOUND_LOWER) begin
            mv = dw[47:24];
          end
          pick = SW'(i);
          done = 1'b1;
        end else if (rank <= low_rank) begin
          low_rank = rank;
          pick     = SW'(i);
        end else if (rank > max_rank) begin
          pick = SW'(i);
          done = 1'b1;
        end
      end
    end
    newdata = {sc_pack[15:0], mv, req.remaining_depth, req.bound_in, current_age};
    hitdata = {bucket[128*hit_slot + 64 + 15 +: 49], current_age};
  end

  always_comb begin
    wbucket = bucket;
    we      = 1'b0;
    waddr   = req_row;
    if (cmd.clear_en) begin
      we      = !clr_cnt[RW];
      waddr   = clr_cnt[RW-1:0];
      wbucket = '0;
    end else if (cmd.decide) begin
      if (req.action == ttsp_pkg::ACT_STORE) begin
        we = 1'b1;
        wbucket[128*pick +: 128] = {newdata, req.key ^ newdata};
        wbucket[128*pick +: 64]  = req.key ^ newdata;
        wbucket[128*pick + 64 +: 64] = newdata;
      end else if (found) begin
        we = 1'b1;
        wbucket[128*hit_slot +: 64]      = req.key ^ hitdata;
        wbucket[128*hit_slot + 64 +: 64] = hitdata;
      end
    end
  end

  // probe result; the packed score field is an unsigned offset
  ttsp_pkg::out_req_t res, res_q;
  logic signed [17:0] sc_out;
  always_comb begin
    res    = '0;
    sc_out = $signed({2'b0, hitdata[63:48]}) + 18'(score_offset);
    if (sc_out > thr && hitdata[16:15] != ttsp_pkg::BOUND_UPPER) begin
      sc_out = sc_out - ply_s;
    end
    if (sc_out < -thr && hitdata[16:15] != ttsp_pkg::BOUND_LOWER) begin
      sc_out = sc_out + ply_s;
    end
    if (req.action != ttsp_pkg::ACT_STORE && found) begin
      res.hit       = 1'b1;
      res.move_out  = hitdata[47:24];
      res.score_out = sc_out[15:0];
      res.bound_out = hitdata[16:15];
      res.depth_out = hitdata[23:17];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_q <= res;
    end
    if (cmd.out_load) begin
      out_data <= res_q;
    end
  end
endmodule
